// ===== src/roi_crop_resize_rgb565_core_defines.svh =====
// assertion macros for the roi crop and resize core
`ifndef ROI_CROP_RESIZE_RGB565_CORE_DEFINES_SVH
`define ROI_CROP_RESIZE_RGB565_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcr assertion failed");
// next-cycle implication
`define RCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcr assertion failed");
`else
`define RCR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/rcr_pkg.sv =====
package rcr_pkg;

  localparam int FRAME_WIDTH_DEF  = 800;
  localparam int FRAME_HEIGHT_DEF = 480;
  localparam int MAX_OUT_SIZE_DEF = 256;

  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [1:0] REG_IMG_SIDE    = 2'd0;
  localparam logic [1:0] REG_LAYOUT      = 2'd1;
  localparam logic [1:0] REG_ROI_PERCENT = 2'd2;

  localparam logic [8:0] IMG_SIDE_RST    = 9'd160;
  localparam logic       LAYOUT_RST      = 1'b0;
  localparam logic [8:0] ROI_PERCENT_RST = 9'd150;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 120;

  typedef struct packed {
    logic [8:0] img_side;
    logic       layout;
    logic [8:0] roi_percent;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic       face_found;
    logic [9:0] face_w;
    logic [9:0] mouth_x;
    logic [9:0] mouth_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

endpackage

// ===== src/rcr_front.sv =====
module rcr_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rcr_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output rcr_pkg::cmd_t                 q_cmd
);

  logic [15:0] px;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign px        = in_tdata[46:31];

  always_comb begin
    q_cmd.start      = (in_tuser == rcr_pkg::OP_START);
    q_cmd.face_found = in_tdata[0];
    q_cmd.face_w     = in_tdata[10:1];
    q_cmd.mouth_x    = in_tdata[20:11];
    q_cmd.mouth_y    = in_tdata[30:21];
    // rgb565 expansion
    q_cmd.red        = {px[15:11], 3'b000};
    q_cmd.green      = {px[10:5], 2'b00};
    q_cmd.blue       = {px[4:0], 3'b000};
  end

endmodule

// ===== src/rcr_queue.sv =====
module rcr_queue #(
  parameter int DEPTH = rcr_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rcr_pkg::cmd_t              push_cmd,
  input  logic                       pop,
  output logic                       q_valid,
  output rcr_pkg::cmd_t              q_cmd,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  rcr_pkg::cmd_t   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign level   = count_r;
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/rcr_back.sv =====
module rcr_back #(
  parameter int FRAME_WIDTH  = rcr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rcr_pkg::FRAME_HEIGHT_DEF,
  parameter int MAX_OUT_SIZE = rcr_pkg::MAX_OUT_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rcr_pkg::cfg_t                  cfg,
  input  logic                           q_valid,
  input  rcr_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rcr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SIDE   = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_DIVEND = 4'd3;
  localparam logic [3:0] S_CLAMP  = 4'd4;
  localparam logic [3:0] S_PLACE  = 4'd5;
  localparam logic [3:0] S_SRC    = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  localparam logic [1:0] DIV_SCALE = 2'd1;
  localparam logic [1:0] DIV_MEAN  = 2'd2;

  localparam logic [4:0] DIV_LAST = 5'd23;
  // ceil(2^26 / 100), exact for every face width times percent product
  localparam logic [19:0] PCT_RECIP = 20'd671089;
  localparam logic [10:0] MIN_SIDE = 11'd64;

  function automatic logic [9:0] place_fn(input logic [9:0] c, input logic [10:0] side,
                                          input logic [10:0] extent);
    logic signed [12:0] p;
    p = $signed({3'b000, c}) - $signed({3'b000, side[10:1]});
    if (p < 0) p = '0;
    if (p + $signed({2'b00, side}) > $signed({2'b00, extent})) begin
      p = $signed({2'b00, extent}) - $signed({2'b00, side});
    end
    if (p < 0) p = '0;
    return p[9:0];
  endfunction

  logic [3:0]  state_r;
  logic        active_r;
  logic [9:0]  left_r, top_r;
  logic [10:0] side_r;
  logic [7:0]  mean_r;
  logic [8:0]  n_r;
  logic        layout_r;
  logic [16:0] nn_r;
  logic [10:0] qs_r;
  logic [8:0]  rs_r;
  logic [8:0]  col_r;
  logic [10:0] qx_r, qy_r;
  logic [8:0]  remx_r, remy_r;
  logic [15:0] lin_r;
  logic [23:0] gsum_r;

  // job start scratch
  logic        use_face_r;
  logic [18:0] prod_r;
  logic [23:0] side_raw_r;
  logic [9:0]  cx_r, cy_r;
  logic [38:0] pct_prod;

  // pending result
  logic [7:0]  red_r, green_r, blue_r;
  logic [17:0] dst_r;
  logic [18:0] src_r;
  logic        last_r;
  logic        idle_pix_r;

  // serial divider
  logic [23:0] div_quo_r;
  logic [16:0] div_rem_r;
  logic [16:0] div_den_r;
  logic [4:0]  div_cnt_r;
  logic [1:0]  div_op_r;

  logic [17:0] rem_sh;
  logic        rem_ge;
  logic [17:0] rem_new;

  logic        out_valid_r;
  logic [rcr_pkg::OUT_DATA_W-1:0] out_data_r;
  logic        out_last_r;

  logic [16:0] lin_inc;
  logic        is_last;
  logic        col_wrap;
  logic [9:0]  remx_sum, remy_sum;
  logic        remx_ovf, remy_ovf;
  logic [23:0] gsum_new;
  logic [8:0]  eff_n;
  logic [10:0] side_clamp;
  logic [11:0] sy, sx;
  logic [22:0] src_calc;
  logic [16:0] step_val;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    rem_sh   = {div_rem_r, div_quo_r[23]};
    rem_ge   = (rem_sh >= {1'b0, div_den_r});
    rem_new  = rem_ge ? (rem_sh - {1'b0, div_den_r}) : rem_sh;

    pct_prod = 39'(prod_r) * 39'(PCT_RECIP);

    lin_inc  = {1'b0, lin_r} + 17'd1;
    is_last  = (lin_inc == nn_r);
    col_wrap = ({1'b0, col_r} + 10'd1) >= {1'b0, n_r};
    remx_sum = {1'b0, remx_r} + {1'b0, rs_r};
    remy_sum = {1'b0, remy_r} + {1'b0, rs_r};
    remx_ovf = (remx_sum >= {1'b0, n_r});
    remy_ovf = (remy_sum >= {1'b0, n_r});
    gsum_new = gsum_r + {16'd0, q_cmd.green};

    if (cfg.img_side == 9'd0) begin
      eff_n = 9'd1;
    end else if (cfg.img_side > 9'(MAX_OUT_SIZE)) begin
      eff_n = 9'(MAX_OUT_SIZE);
    end else begin
      eff_n = cfg.img_side;
    end

    if (side_raw_r < 24'(MIN_SIDE)) begin
      side_clamp = MIN_SIDE;
    end else if (side_raw_r > 24'(FRAME_HEIGHT)) begin
      side_clamp = 11'(FRAME_HEIGHT);
    end else begin
      side_clamp = side_raw_r[10:0];
    end

    sy       = {2'b00, top_r} + {1'b0, qy_r};
    sx       = {2'b00, left_r} + {1'b0, qx_r};
    src_calc = 23'(sy) * 23'(FRAME_WIDTH) + 23'(sx);
    step_val = idle_pix_r ? 17'd0 : (layout_r ? 17'd1 : nn_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      left_r      <= '0;
      top_r       <= '0;
      side_r      <= '0;
      mean_r      <= '0;
      n_r         <= 9'd1;
      layout_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.start) begin
              prod_r     <= 19'(q_cmd.face_w) * 19'(cfg.roi_percent);
              use_face_r <= q_cmd.face_found && (q_cmd.face_w != 10'd0);
              cx_r       <= q_cmd.mouth_x;
              cy_r       <= q_cmd.mouth_y;
              state_r    <= S_SIDE;
            end else if (!active_r) begin
              red_r      <= '0;
              green_r    <= '0;
              blue_r     <= '0;
              dst_r      <= '0;
              src_r      <= '0;
              last_r     <= 1'b0;
              idle_pix_r <= 1'b1;
              state_r    <= S_OUT;
            end else begin
              red_r      <= q_cmd.red;
              green_r    <= q_cmd.green;
              blue_r     <= q_cmd.blue;
              idle_pix_r <= 1'b0;
              dst_r      <= layout_r ? (18'({lin_r, 1'b0}) + 18'(lin_r)) : 18'(lin_r);
              gsum_r     <= gsum_new;
              lin_r      <= lin_inc[15:0];
              if (!col_wrap) begin
                col_r  <= col_r + 9'd1;
                qx_r   <= qx_r + qs_r + 11'(remx_ovf);
                remx_r <= remx_ovf ? 9'(remx_sum - {1'b0, n_r}) : remx_sum[8:0];
              end else begin
                col_r  <= '0;
                qx_r   <= '0;
                remx_r <= '0;
                qy_r   <= qy_r + qs_r + 11'(remy_ovf);
                remy_r <= remy_ovf ? 9'(remy_sum - {1'b0, n_r}) : remy_sum[8:0];
              end
              if (is_last) begin
                active_r  <= 1'b0;
                last_r    <= 1'b1;
                src_r     <= '0;
                div_quo_r <= gsum_new;
                div_rem_r <= '0;
                div_den_r <= nn_r;
                div_cnt_r <= '0;
                div_op_r  <= DIV_MEAN;
                state_r   <= S_DIV;
              end else begin
                last_r  <= 1'b0;
                state_r <= S_SRC;
              end
            end
          end
        end
        S_SIDE: begin
          if (use_face_r) begin
            // percent product over 100 by reciprocal multiply
            side_raw_r <= 24'(pct_prod[38:26]);
          end else begin
            side_raw_r <= 24'(FRAME_HEIGHT);
            cx_r       <= 10'(FRAME_WIDTH / 2);
            cy_r       <= 10'(FRAME_HEIGHT / 2);
          end
          state_r <= S_CLAMP;
        end
        S_DIV: begin
          div_rem_r <= rem_new[16:0];
          div_quo_r <= {div_quo_r[22:0], rem_ge};
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == DIV_LAST) begin
            state_r <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          unique case (div_op_r)
            DIV_SCALE: begin
              qs_r    <= div_quo_r[10:0];
              rs_r    <= div_rem_r[8:0];
              state_r <= S_SRC;
            end
            default: begin
              mean_r  <= div_quo_r[7:0];
              state_r <= S_OUT;
            end
          endcase
        end
        S_CLAMP: begin
          side_r   <= side_clamp;
          n_r      <= eff_n;
          layout_r <= cfg.layout;
          state_r  <= S_PLACE;
        end
        S_PLACE: begin
          left_r     <= place_fn(cx_r, side_r, 11'(FRAME_WIDTH));
          top_r      <= place_fn(cy_r, side_r, 11'(FRAME_HEIGHT));
          nn_r       <= 17'(n_r) * 17'(n_r);
          col_r      <= '0;
          qx_r       <= '0;
          qy_r       <= '0;
          remx_r     <= '0;
          remy_r     <= '0;
          lin_r      <= '0;
          gsum_r     <= '0;
          active_r   <= 1'b1;
          red_r      <= '0;
          green_r    <= '0;
          blue_r     <= '0;
          dst_r      <= '0;
          last_r     <= 1'b0;
          idle_pix_r <= 1'b0;
          div_quo_r  <= 24'(side_r);
          div_rem_r  <= '0;
          div_den_r  <= 17'(n_r);
          div_cnt_r  <= '0;
          div_op_r   <= DIV_SCALE;
          state_r    <= S_DIV;
        end
        S_SRC: begin
          src_r   <= src_calc[18:0];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_last_r  <= last_r;
            out_data_r  <= {5'd0, mean_r, step_val, dst_r, blue_r, green_r, red_r,
                            src_r, side_r[8:0], top_r, left_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/roi_crop_resize_rgb565_core.sv =====
// Nearest-neighbor crop and resize of an RGB565 frame into an 8-bit RGB image. A start beat
// (in_tuser low) carries a face observation and fixes a square region, clamped to 64..frame
// height and kept inside the frame; each later pixel beat (in_tuser high) brings the word
// fetched at the src_index of the previous result and yields one result beat with the
// expanded color, its destination byte index and the next source index. out_tlast marks the
// final pixel, whose beat carries the green mean. Once the back takes it, a start runs the
// 24-step serial divide of region side over output size (the percent scaling is a reciprocal
// multiply); a pixel passes through the source index and output states; the final pixel runs
// the 24-step divide for the mean. A stalled result holds the back until it is taken. A
// two-beat queue sits between the accepting front and the working back, and the result
// register lets the next item queue while a result waits.
`include "roi_crop_resize_rgb565_core_defines.svh"

module roi_crop_resize_rgb565_core #(
  parameter int FRAME_WIDTH  = rcr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rcr_pkg::FRAME_HEIGHT_DEF,
  parameter int MAX_OUT_SIZE = rcr_pkg::MAX_OUT_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // face_found[0], face width[10:1], mouth_x[20:11], mouth_y[30:21], pixel[46:31]
  input  logic [rcr_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode[0]
  input  logic                           in_tuser,
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // roi_x[9:0], roi_y[19:10], roi_size[28:20], src_index[47:29], red[55:48],
  // green[63:56], blue[71:64], dest_index[89:72], channel_step[106:90], roi_mean[114:107]
  output logic [rcr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [8:0]                     cfg_data
);

  localparam int LW = $clog2(rcr_pkg::QUEUE_DEPTH + 1);

  rcr_pkg::cfg_t cfg_r;
  rcr_pkg::cmd_t push_cmd, pop_cmd;
  logic          q_push, q_pop, q_valid, q_full;
  logic [LW-1:0] q_level;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.img_side    <= rcr_pkg::IMG_SIDE_RST;
      cfg_r.layout      <= rcr_pkg::LAYOUT_RST;
      cfg_r.roi_percent <= rcr_pkg::ROI_PERCENT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rcr_pkg::REG_IMG_SIDE:    cfg_r.img_side    <= cfg_data;
        rcr_pkg::REG_LAYOUT:      cfg_r.layout      <= cfg_data[0];
        rcr_pkg::REG_ROI_PERCENT: cfg_r.roi_percent <= cfg_data;
        default: ; // unknown index ignored
      endcase
    end
  end

  // front: accept and classify beats
  rcr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // queue between front and back
  rcr_queue #(
    .DEPTH (rcr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .full     (q_full),
    .level    (q_level)
  );

  // back: region setup, resampling walk, mean
  rcr_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .MAX_OUT_SIZE (MAX_OUT_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // backpressure on the input only when the queue is full
  `RCR_ASSERT_NOW(a_ready_full, clk, rst_n, !in_tready, q_level == LW'(rcr_pkg::QUEUE_DEPTH))
  // queue never overfills
  `RCR_ASSERT_NOW(a_level_max, clk, rst_n, 1'b1, q_level <= LW'(rcr_pkg::QUEUE_DEPTH))
  // the final pixel beat points at source index zero
  `RCR_ASSERT_NOW(a_last_src, clk, rst_n, out_tvalid && out_tlast, out_tdata[47:29] == 19'd0)
  // a beat accepted into an empty queue is held there next cycle
  `RCR_ASSERT_NEXT(a_queue_fill, clk, rst_n, in_tvalid && in_tready && (q_level == '0),
                   q_level != '0)

endmodule
